### hw/rtl/vortex_indicator_stream_defines.svh
// Assertion macros for the vortex indicator stream checker.
// Needs a clock named clock and a reset named reset where it is used.
`ifndef VORTEX_INDICATOR_STREAM_DEFINES_SVH
`define VORTEX_INDICATOR_STREAM_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define VIS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("vortex indicator check failed");

// Check a property on every clock edge, reset included.
`define VIS_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("vortex indicator reset check failed");

`endif

### hw/rtl/vis_pkg.sv
// Shared constants, types and state codes for the vortex indicator stream.
// No dependencies; used by the top level and its checker.
package vis_pkg;

   // window and fixed point format
   localparam int WINDOW_MAX    = 64;
   localparam int FRACTION_BITS = 16;
   localparam int PRICE_W       = 32;
   localparam int LEN_W         = 7;
   localparam int OUT_W         = 24;
   localparam int INT_BITS      = OUT_W - FRACTION_BITS;
   localparam int SLOT_W        = $clog2(WINDOW_MAX);
   localparam int SUM_W         = PRICE_W + SLOT_W;
   localparam int STEP_W        = $clog2(OUT_W);

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(14);

   typedef logic [PRICE_W-1:0] price_type;
   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [OUT_W-1:0]   ratio_type;
   typedef logic [LEN_W-1:0]   len_type;
   typedef logic [SLOT_W-1:0]  slot_type;

   localparam ratio_type OUT_MAX = '1;

   // one window entry: the three per-bar movements
   typedef struct packed {
      price_type vm_plus;
      price_type vm_minus;
      price_type range;
   } bar_move_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_RANGE,
      ST_DROP,
      ST_ADD,
      ST_CHECK,
      ST_OVF,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

### hw/rtl/vis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### hw/rtl/vortex_indicator_stream.sv
// Vortex indicator over a stream of price bars (high, low, close, 16 fraction bits).
// Depends on vis_pkg and vis_ram.
//
// Usage:
//   req_*  : one price bar per word, valid/ready. A word is taken only while the
//            block is idle; it then works on that bar alone.
//   rsp_*  : one result word per bar, valid/ready, held in an output register.
//            rsp_result_valid is low during warm-up (fewer than window_length
//            movements held), and then both ratios and saturation flag are zero.
//   csr_*  : write csr_window_length with csr_write_enable while idle; a write
//            clears the previous bar, the sums, the write slot and the bar count.
//            Length 0 acts as 1, lengths above 64 act as 64.
// Divider: each ratio runs on one shared restoring divider, one quotient bit per
//   cycle over 24 bits plus an overflow check; a saturated ratio skips its
//   division steps. The window sits in one 64-entry RAM with a registered read.
// Reset: window_length returns to 14, history clears, no result is pending.
// Stall: a finished result waits in the output register; the block stays busy
//   holding its next result until rsp_ready takes the waiting word.
module vortex_indicator_stream
   import vis_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  vis_pkg::price_type  req_high_price,
   input  vis_pkg::price_type  req_low_price,
   input  vis_pkg::price_type  req_close_price,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output vis_pkg::ratio_type  rsp_vi_plus_ratio,
   output vis_pkg::ratio_type  rsp_vi_minus_ratio,
   output logic                rsp_result_valid,
   output logic                rsp_ratio_saturated,
   input  logic                csr_write_enable,
   input  vis_pkg::len_type    csr_window_length
);

   state_type    state_ff, state_in;
   len_type      len_cfg_ff;
   len_type      len_eff, full_mark;
   price_type    high_ff, low_ff, close_ff;
   price_type    prev_high_ff, prev_low_ff, prev_close_ff;
   price_type    vmp_ff, vmm_ff, d_hl_ff, d_hc_ff, d_lc_ff, tr_ff, tr_in;
   slot_type     slot_ff, cur_slot_ff, slot_eff, slot_next;
   len_type      bars_ff;
   sum_type      sum_p_ff, sum_m_ff, sum_r_ff;
   sum_type      rem_ff;
   ratio_type    dvd_ff, quot;
   logic [STEP_W-1:0] step_ff;
   logic         second_ff, sat_ff, res_valid_ff;
   ratio_type    vip_ff, vim_ff;
   logic         rsp_valid_ff;
   ratio_type    rsp_plus_ff, rsp_minus_ff;
   logic         rsp_res_ff, rsp_sat_ff;

   // control strobes
   logic         take_word, do_diff, do_range, do_drop, do_add, do_check;
   logic         do_ovf, do_step, load_rsp;

   // datapath helpers
   logic         have_prev, window_full, result_ok, ovf, last_step, qbit;
   sum_type      num;
   logic [SUM_W+FRACTION_BITS-1:0] num_ext;
   logic [SUM_W:0] trial, shifted;
   bar_move_type ram_rd, ram_wr;
   slot_type     ram_rd_addr;

   function automatic price_type abs_diff(input price_type a, input price_type b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   // clamp the programmed length to 1..WINDOW_MAX
   always_comb begin
      if (len_cfg_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_cfg_ff > LEN_W'(WINDOW_MAX)) begin
         len_eff = LEN_W'(WINDOW_MAX);
      end else begin
         len_eff = len_cfg_ff;
      end
   end

   assign full_mark   = len_eff + LEN_W'(1);
   assign have_prev   = (bars_ff != '0);
   assign window_full = (bars_ff >= full_mark);
   assign result_ok   = window_full && (sum_r_ff != '0);

   // wrap the write slot into the current window
   assign slot_eff  = (LEN_W'(slot_ff) >= len_eff) ? '0 : slot_ff;
   assign slot_next = (LEN_W'(cur_slot_ff) + LEN_W'(1) >= len_eff) ?
                      '0 : cur_slot_ff + SLOT_W'(1);

   // true range: largest of the three distances
   always_comb begin
      tr_in = d_hl_ff;
      if (d_hc_ff > tr_in) begin
         tr_in = d_hc_ff;
      end
      if (d_lc_ff > tr_in) begin
         tr_in = d_lc_ff;
      end
   end

   // divider operands: overflow check, then one quotient bit per cycle
   assign num       = second_ff ? sum_m_ff : sum_p_ff;
   assign num_ext   = {num, {FRACTION_BITS{1'b0}}};
   assign ovf       = (num >> INT_BITS) >= sum_r_ff;
   assign shifted   = {rem_ff, dvd_ff[OUT_W-1]};
   assign trial     = shifted - {1'b0, sum_r_ff};
   assign qbit      = !trial[SUM_W];
   assign quot      = {dvd_ff[OUT_W-2:0], qbit};
   assign last_step = (step_ff == STEP_W'(OUT_W - 1));

   // window RAM: read the oldest entry, write the new one in its place
   assign ram_rd_addr     = (state_ff == ST_IDLE) ? slot_eff : cur_slot_ff;
   assign ram_wr.vm_plus  = vmp_ff;
   assign ram_wr.vm_minus = vmm_ff;
   assign ram_wr.range    = tr_ff;

   vis_ram #(
      .WIDTH ($bits(bar_move_type)),
      .DEPTH (WINDOW_MAX)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (do_add && have_prev),
      .wr_addr (cur_slot_ff),
      .wr_data (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF:  state_in = ST_RANGE;
         ST_RANGE: state_in = ST_DROP;
         ST_DROP:  state_in = ST_ADD;
         ST_ADD:   state_in = ST_CHECK;
         ST_CHECK: state_in = result_ok ? ST_OVF : ST_DONE;
         ST_OVF: begin
            if (!ovf) begin
               state_in = ST_DIV;
            end else if (second_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (last_step) begin
               state_in = second_ff ? ST_DONE : ST_OVF;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      take_word = 1'b0;
      do_diff   = 1'b0;
      do_range  = 1'b0;
      do_drop   = 1'b0;
      do_add    = 1'b0;
      do_check  = 1'b0;
      do_ovf    = 1'b0;
      do_step   = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            take_word = req_valid;
         end
         ST_DIFF:  do_diff  = 1'b1;
         ST_RANGE: do_range = 1'b1;
         ST_DROP:  do_drop  = 1'b1;
         ST_ADD:   do_add   = 1'b1;
         ST_CHECK: do_check = 1'b1;
         ST_OVF:   do_ovf   = 1'b1;
         ST_DIV:   do_step  = 1'b1;
         ST_DONE:  load_rsp = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_cfg_ff <= LEN_RESET;
      end else if (csr_write_enable) begin
         len_cfg_ff <= csr_window_length;
      end
   end

   // history: previous bar, slot, bar count and running sums
   always_ff @(posedge clock) begin
      if (reset || csr_write_enable) begin
         prev_high_ff  <= '0;
         prev_low_ff   <= '0;
         prev_close_ff <= '0;
         slot_ff       <= '0;
         bars_ff       <= '0;
         sum_p_ff      <= '0;
         sum_m_ff      <= '0;
         sum_r_ff      <= '0;
      end else begin
         // drop the oldest movements once the window is full
         if (do_drop && have_prev && window_full) begin
            sum_p_ff <= sum_p_ff - SUM_W'(ram_rd.vm_plus);
            sum_m_ff <= sum_m_ff - SUM_W'(ram_rd.vm_minus);
            sum_r_ff <= sum_r_ff - SUM_W'(ram_rd.range);
         end
         // add the new movements, advance slot and count, keep this bar
         if (do_add) begin
            if (have_prev) begin
               sum_p_ff <= sum_p_ff + SUM_W'(vmp_ff);
               sum_m_ff <= sum_m_ff + SUM_W'(vmm_ff);
               sum_r_ff <= sum_r_ff + SUM_W'(tr_ff);
               slot_ff  <= slot_next;
            end
            if (bars_ff < full_mark) begin
               bars_ff <= bars_ff + LEN_W'(1);
            end
            prev_high_ff  <= high_ff;
            prev_low_ff   <= low_ff;
            prev_close_ff <= close_ff;
         end
      end
   end

   // bar capture and movement terms
   always_ff @(posedge clock) begin
      if (take_word) begin
         high_ff     <= req_high_price;
         low_ff      <= req_low_price;
         close_ff    <= req_close_price;
         cur_slot_ff <= slot_eff;
      end
      if (do_diff) begin
         vmp_ff  <= abs_diff(high_ff, prev_low_ff);
         vmm_ff  <= abs_diff(low_ff, prev_high_ff);
         d_hl_ff <= abs_diff(high_ff, low_ff);
         d_hc_ff <= abs_diff(high_ff, prev_close_ff);
         d_lc_ff <= abs_diff(low_ff, prev_close_ff);
      end
      if (do_range) begin
         tr_ff <= tr_in;
      end
   end

   // shared divider: VI+ first, then VI-
   always_ff @(posedge clock) begin
      if (do_check) begin
         res_valid_ff <= window_full;
         sat_ff       <= 1'b0;
         second_ff    <= 1'b0;
         vip_ff       <= '0;
         vim_ff       <= '0;
      end
      if (do_ovf) begin
         if (ovf) begin
            sat_ff    <= 1'b1;
            second_ff <= 1'b1;
            if (second_ff) begin
               vim_ff <= OUT_MAX;
            end else begin
               vip_ff <= OUT_MAX;
            end
         end else begin
            rem_ff  <= num >> INT_BITS;
            dvd_ff  <= num_ext[OUT_W-1:0];
            step_ff <= '0;
         end
      end
      if (do_step) begin
         rem_ff  <= qbit ? trial[SUM_W-1:0] : shifted[SUM_W-1:0];
         dvd_ff  <= quot;
         step_ff <= step_ff + STEP_W'(1);
         if (last_step) begin
            second_ff <= 1'b1;
            if (second_ff) begin
               vim_ff <= quot;
            end else begin
               vip_ff <= quot;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_plus_ff  <= vip_ff;
         rsp_minus_ff <= vim_ff;
         rsp_res_ff   <= res_valid_ff;
         rsp_sat_ff   <= sat_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vi_plus_ratio   = rsp_plus_ff;
   assign rsp_vi_minus_ratio  = rsp_minus_ff;
   assign rsp_result_valid    = rsp_res_ff;
   assign rsp_ratio_saturated = rsp_sat_ff;

endmodule

### hw/rtl/vis_checker.sv
// Port-level checks for the vortex indicator stream, bound to the top level.
// Depends on vis_pkg and vortex_indicator_stream_defines.svh.
`include "vortex_indicator_stream_defines.svh"

module vis_checker
   import vis_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input vis_pkg::price_type  req_high_price,
   input vis_pkg::price_type  req_low_price,
   input vis_pkg::price_type  req_close_price,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input vis_pkg::ratio_type  rsp_vi_plus_ratio,
   input vis_pkg::ratio_type  rsp_vi_minus_ratio,
   input logic                rsp_result_valid,
   input logic                rsp_ratio_saturated,
   input logic                csr_write_enable,
   input vis_pkg::len_type    csr_window_length
);

   logic any_bar;

   // any bar field in flight, kept for visibility of the input word
   assign any_bar = |{req_high_price, req_low_price, req_close_price, csr_window_length,
                      csr_write_enable};

   // hold a stalled result word
   `VIS_ASSERT(rsp_hold_chk, rsp_valid && !rsp_ready |=> rsp_valid)

   // warm-up words carry zeros only
   `VIS_ASSERT(warmup_zero_chk, rsp_valid && !rsp_result_valid |->
      rsp_vi_plus_ratio == '0 && rsp_vi_minus_ratio == '0 && !rsp_ratio_saturated)

   // saturation flag means a ratio sits at the maximum
   `VIS_ASSERT(sat_max_chk, rsp_valid && rsp_ratio_saturated |->
      rsp_vi_plus_ratio == OUT_MAX || rsp_vi_minus_ratio == OUT_MAX)

   // one bar at a time: busy right after taking a word
   `VIS_ASSERT(busy_chk, req_valid && req_ready && (any_bar || !any_bar) |=> !req_ready)

   // no result pending right after reset
   `VIS_ASSERT_ALWAYS(reset_chk, $past(reset) |-> !rsp_valid)

endmodule

bind vortex_indicator_stream vis_checker u_vis_checker (.*);

### test/vortex_indicator_stream_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for vortex_indicator_stream: price bars in, VI+/VI- words out.
// Depends on vis_pkg and the block itself; carries its own bit-true indicator model.
module vortex_indicator_stream_tb;
   import vis_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int PHASE_BARS   = 115;
   localparam int REPORT_MAX   = 10;

   typedef enum logic {ROW_BAR, ROW_WINDOW} row_kind_t;

   typedef struct packed {
      ratio_type plus;
      ratio_type minus;
      logic      ok;
      logic      clipped;
   } vi_result_t;

   typedef struct {
      row_kind_t  kind;
      price_type  high;
      price_type  low;
      price_type  close;
      len_type    span;
      bit         known;
      vi_result_t want;
   } bar_row_t;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   price_type req_high_price = '0;
   price_type req_low_price = '0;
   price_type req_close_price = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   ratio_type rsp_vi_plus_ratio;
   ratio_type rsp_vi_minus_ratio;
   logic      rsp_result_valid;
   logic      rsp_ratio_saturated;
   logic      csr_write_enable = 1'b0;
   len_type   csr_window_length = LEN_RESET;

   // indicator model state
   len_type   win_len;
   price_type last_high, last_low, last_close;
   price_type plus_ring [WINDOW_MAX];
   price_type minus_ring [WINDOW_MAX];
   price_type range_ring [WINDOW_MAX];
   slot_type  ring_slot;
   len_type   bar_count;
   sum_type   plus_total, minus_total, range_total;

   vi_result_t vi_expected [$];
   bar_row_t   directed_rows [$];

   int     req_idle_pct = 0;
   int     rsp_idle_pct = 0;
   int     cycle_count = 0;
   int     mismatch_count = 0;
   int     bars_sent = 0;
   int     words_checked = 0;
   int     windows_written = 0;
   int     clipped_count = 0;
   int     flat_count = 0;
   longint bar_level = 64'h4000_0000;

   vortex_indicator_stream dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_high_price      (req_high_price),
      .req_low_price       (req_low_price),
      .req_close_price     (req_close_price),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_vi_plus_ratio   (rsp_vi_plus_ratio),
      .rsp_vi_minus_ratio  (rsp_vi_minus_ratio),
      .rsp_result_valid    (rsp_result_valid),
      .rsp_ratio_saturated (rsp_ratio_saturated),
      .csr_write_enable    (csr_write_enable),
      .csr_window_length   (csr_window_length)
   );

   always #10 clock = ~clock;

   // abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // stall the result channel at the current rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   function automatic price_type price_gap(price_type a, price_type b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // restoring divide: integer part, then FRACTION_BITS fraction bits, truncated
   function automatic ratio_type vi_divide(input sum_type num, input sum_type den,
                                           output logic clipped);
      sum_type                  whole;
      logic [SUM_W:0]           rem;
      logic [FRACTION_BITS-1:0] frac;
      int                       i;
      whole   = num / den;
      rem     = {1'b0, num % den};
      frac    = '0;
      clipped = 1'b0;
      if (whole > sum_type'(OUT_MAX >> FRACTION_BITS)) begin
         clipped = 1'b1;
         return OUT_MAX;
      end
      for (i = 0; i < FRACTION_BITS; i++) begin
         rem  = rem << 1;
         frac = frac << 1;
         if (rem >= {1'b0, den}) begin
            rem     = rem - {1'b0, den};
            frac[0] = 1'b1;
         end
      end
      return {whole[INT_BITS-1:0], frac};
   endfunction

   function automatic void clear_history();
      last_high   = '0;
      last_low    = '0;
      last_close  = '0;
      ring_slot   = '0;
      bar_count   = '0;
      plus_total  = '0;
      minus_total = '0;
      range_total = '0;
   endfunction

   // advance the indicator by one bar and return the word it should produce
   function automatic vi_result_t vortex_step(price_type hi, price_type lo, price_type cl);
      vi_result_t res;
      price_type  up_move, down_move, bar_range;
      int         span, slot;
      logic       clip_p, clip_m;
      res  = '0;
      span = (win_len == 0) ? 1 : (int'(win_len) > WINDOW_MAX) ? WINDOW_MAX : int'(win_len);
      if (bar_count > 0) begin
         up_move   = price_gap(hi, last_low);
         down_move = price_gap(lo, last_high);
         bar_range = price_gap(hi, lo);
         if (price_gap(hi, last_close) > bar_range) bar_range = price_gap(hi, last_close);
         if (price_gap(lo, last_close) > bar_range) bar_range = price_gap(lo, last_close);
         slot = int'(ring_slot);
         if (slot >= span) slot = 0;
         // drop the bar leaving a full window
         if (int'(bar_count) >= span + 1) begin
            plus_total  -= sum_type'(plus_ring[slot]);
            minus_total -= sum_type'(minus_ring[slot]);
            range_total -= sum_type'(range_ring[slot]);
         end
         plus_ring[slot]  = up_move;
         minus_ring[slot] = down_move;
         range_ring[slot] = bar_range;
         plus_total  += sum_type'(up_move);
         minus_total += sum_type'(down_move);
         range_total += sum_type'(bar_range);
         slot++;
         ring_slot = slot_type'((slot >= span) ? 0 : slot);
      end
      if (int'(bar_count) < span + 1) bar_count++;
      if (int'(bar_count) >= span + 1) begin
         res.ok = 1'b1;
         if (range_total != 0) begin
            res.plus    = vi_divide(plus_total, range_total, clip_p);
            res.minus   = vi_divide(minus_total, range_total, clip_m);
            res.clipped = clip_p | clip_m;
         end else begin
            flat_count++;
         end
      end
      if (res.clipped) clipped_count++;
      last_high  = hi;
      last_low   = lo;
      last_close = cl;
      return res;
   endfunction

   task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
   endtask

   // compare each result word with the oldest expectation
   always @(posedge clock) begin : result_check
      vi_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (vi_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("result word with nothing expected: %0h %0h %b %b",
                        rsp_vi_plus_ratio, rsp_vi_minus_ratio,
                        rsp_result_valid, rsp_ratio_saturated);
         end else begin
            want = vi_expected.pop_front();
            check_field("vi_plus_ratio", want.plus, rsp_vi_plus_ratio);
            check_field("vi_minus_ratio", want.minus, rsp_vi_minus_ratio);
            check_field("result_valid", OUT_W'(want.ok), OUT_W'(rsp_result_valid));
            check_field("ratio_saturated", OUT_W'(want.clipped), OUT_W'(rsp_ratio_saturated));
            words_checked++;
         end
      end
   end

   // offer one bar, idling first at the sender's rate, and hold it until taken
   task automatic send_bar(price_type hi, price_type lo, price_type cl);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid       <= 1'b1;
      req_high_price  <= hi;
      req_low_price   <= lo;
      req_close_price <= cl;
      do @(posedge clock); while (!req_ready);
      bars_sent++;
   endtask

   task automatic wait_drained();
      while (vi_expected.size() != 0) @(posedge clock);
   endtask

   // write the window length once every pending word is out
   task automatic set_window(len_type span);
      req_valid <= 1'b0;
      wait_drained();
      csr_write_enable  <= 1'b1;
      csr_window_length <= span;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      win_len = span;
      clear_history();
      windows_written++;
   endtask

   // random bar: drifting market, flat, tight, wick, raw noise or full-scale extreme bars
   task automatic make_bar(output price_type hi, output price_type lo, output price_type cl);
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 45) begin
         bar_level += longint'($urandom_range(1 << 20)) - longint'(1 << 19);
         if (bar_level < (64'd1 << 24)) bar_level = 64'd1 << 24;
         if (bar_level > (64'd1 << 31)) bar_level = 64'd1 << 31;
         hi = price_type'(bar_level + longint'($urandom_range(1 << 18)));
         lo = price_type'(bar_level - longint'($urandom_range(1 << 18)));
         cl = $urandom_range(hi, lo);
      end else if (kind < 60) begin
         hi = price_type'(bar_level);
         lo = hi;
         cl = hi;
      end else if (kind < 72) begin
         lo = price_type'(bar_level);
         hi = lo + price_type'($urandom_range(3));
         cl = lo;
      end else if (kind < 80) begin
         hi = price_type'(bar_level);
         lo = hi - price_type'($urandom_range(hi));
         cl = hi;
      end else if (kind < 95) begin
         hi = $urandom;
         lo = $urandom;
         cl = $urandom;
      end else begin
         hi = $urandom_range(1) ? '1 : '0;
         lo = $urandom_range(1) ? '1 : '0;
         cl = $urandom_range(1) ? '1 : '0;
      end
   endtask

   function automatic void add_bar(price_type hi, price_type lo, price_type cl);
      bar_row_t row;
      row       = '{ROW_BAR, hi, lo, cl, '0, 1'b0, '0};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_known(price_type hi, price_type lo, price_type cl,
                                     ratio_type plus, ratio_type minus, logic ok, logic clipped);
      bar_row_t row;
      row      = '{ROW_BAR, hi, lo, cl, '0, 1'b1, '0};
      row.want = '{plus, minus, ok, clipped};
      directed_rows.push_back(row);
   endfunction

   function automatic void add_window(len_type span);
      bar_row_t row;
      row = '{ROW_WINDOW, '0, '0, '0, span, 1'b0, '0};
      directed_rows.push_back(row);
   endfunction

   initial begin : stimulus
      int        phase_plan [12];
      int        phase, n;
      price_type hi, lo, cl;
      vi_result_t predicted;

      phase_plan = '{1, 64, 2, 127, 0, 3, -1, 17, -1, 1, 64, -1};
      win_len    = LEN_RESET;
      clear_history();

      // warm-up at the reset length
      add_known(32'h0001_0000, 32'h0000_8000, 32'h0000_C000, '0, '0, 1'b0, 1'b0);
      add_known(32'h0002_0000, 32'h0001_0000, 32'h0001_8000, '0, '0, 1'b0, 1'b0);
      // single-bar window: first bar warms up, then flat range and a clipped ratio
      add_window(1);
      add_known(32'd10, 32'd5, 32'd8, '0, '0, 1'b0, 1'b0);
      add_bar(32'd0, 32'd0, 32'd0);
      add_bar(32'd7, 32'd7, 32'd7);
      add_known(32'd7, 32'd7, 32'd7, '0, '0, 1'b1, 1'b0);
      add_bar(32'd1000, 32'd0, 32'd1000);
      add_known(32'd1000, 32'd999, 32'd1000, OUT_MAX, 24'h01_0000, 1'b1, 1'b1);
      // full-scale prices
      add_bar(32'd0, 32'd0, 32'd0);
      add_known('1, '1, '1, 24'h01_0000, 24'h01_0000, 1'b1, 1'b0);
      add_known('0, '0, '0, 24'h01_0000, 24'h01_0000, 1'b1, 1'b0);
      add_known('1, '0, '1, 24'h01_0000, '0, 1'b1, 1'b0);
      add_bar('0, '1, '0);
      // zero length acts as one
      add_window(0);
      add_known(32'd5, 32'd3, 32'd4, '0, '0, 1'b0, 1'b0);
      add_bar(32'd9, 32'd2, 32'd6);
      // oversized length acts as the maximum
      add_window(127);
      add_known(32'h0010_0000, 32'h000F_0000, 32'h000F_8000, '0, '0, 1'b0, 1'b0);
      add_known(32'h0011_0000, 32'h0010_0000, 32'h0010_8000, '0, '0, 1'b0, 1'b0);
      // short window that fills and wraps
      add_window(3);
      add_bar(32'h0012_0000, 32'h0010_0000, 32'h0011_0000);
      add_bar(32'h0013_0000, 32'h0011_8000, 32'h0012_8000);
      add_bar(32'h0012_5000, 32'h000F_0000, 32'h0010_0000);
      add_bar(32'h0014_0000, 32'h0012_0000, 32'h0013_8000);
      add_bar(32'h0015_0000, 32'h0013_0000, 32'h0014_0000);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 37;
      rsp_idle_pct = 69;

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WINDOW) begin
            set_window(directed_rows[i].span);
         end else begin
            send_bar(directed_rows[i].high, directed_rows[i].low, directed_rows[i].close);
            predicted = vortex_step(directed_rows[i].high, directed_rows[i].low,
                                    directed_rows[i].close);
            vi_expected.push_back(directed_rows[i].known ? directed_rows[i].want : predicted);
         end
      end

      // random phases: receiver-heavy idling, then sender-heavy, then none
      for (phase = 0; phase < 12; phase++) begin
         req_idle_pct = (phase < 4) ? 37 : (phase < 8) ? 69 : 0;
         rsp_idle_pct = (phase < 4) ? 69 : (phase < 8) ? 37 : 0;
         set_window((phase_plan[phase] < 0) ? len_type'($urandom_range(63, 4))
                                            : len_type'(phase_plan[phase]));
         for (n = 0; n < PHASE_BARS; n++) begin
            // now and then hold off until the block has emptied
            if (n == PHASE_BARS / 2 || $urandom_range(99) < 2) begin
               req_valid <= 1'b0;
               wait_drained();
            end
            make_bar(hi, lo, cl);
            send_bar(hi, lo, cl);
            vi_expected.push_back(vortex_step(hi, lo, cl));
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (80) @(posedge clock);

      $display("Sent %0d bars across %0d window lengths; checked %0d result words.",
               bars_sent, windows_written, words_checked);
      $display("Clipped ratios: %0d, flat-range windows: %0d, field mismatches: %0d.",
               clipped_count, flat_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
